@@ hdl/stt_pkg.sv @@
package stt_pkg;

    localparam int TIMER_SLOTS_DEF = 8;
    localparam int TASK_W          = 8;
    localparam int SIGNAL_W        = 8;
    localparam int TICKS_W         = 16;

    typedef enum logic [1:0] {
        REQ_TICK         = 2'd0,
        REQ_SET_ONCE     = 2'd1,
        REQ_SET_PERIODIC = 2'd2,
        REQ_DELETE       = 2'd3
    } t_req_type;

    typedef enum logic [1:0] {
        ST_UPDATED = 2'd0,
        ST_NEW     = 2'd1,
        ST_NONE    = 2'd2
    } t_status;

    typedef enum logic {
        KIND_EVENT = 1'b0,
        KIND_ACK   = 1'b1
    } t_kind;

    typedef enum logic [1:0] {
        S_IDLE,
        S_RUN,
        S_FINISH
    } t_state;

    typedef struct packed {
        t_req_type             req_type;
        logic [TASK_W-1:0]     task_id;
        logic [SIGNAL_W-1:0]   signal_code;
        logic [TICKS_W-1:0]    ticks;
    } t_req;

    typedef struct packed {
        logic    tok;
        t_status status;
    } t_link;

    typedef struct packed {
        logic                  emit;
        logic [TASK_W-1:0]     task_id;
        logic [SIGNAL_W-1:0]   signal_code;
    } t_evt;

endpackage

@@ hdl/stt_in_if.sv @@
interface stt_in_if;
    import stt_pkg::*;

    logic                valid;
    logic                ready;
    logic [1:0]          req_type;
    logic [TASK_W-1:0]   task_id;
    logic [SIGNAL_W-1:0] signal_code;
    logic [TICKS_W-1:0]  ticks;

    modport source (output valid, req_type, task_id, signal_code, ticks, input ready);
    modport sink   (input valid, req_type, task_id, signal_code, ticks, output ready);
endinterface

@@ hdl/stt_out_if.sv @@
interface stt_out_if;
    import stt_pkg::*;

    logic                valid;
    logic                ready;
    logic                kind;
    logic [TASK_W-1:0]   event_task;
    logic [SIGNAL_W-1:0] event_signal;
    logic [1:0]          status;
    logic                last;

    modport source (output valid, kind, event_task, event_signal, status, last, input ready);
    modport sink   (input valid, kind, event_task, event_signal, status, last, output ready);
endinterface

@@ hdl/stt_cell.sv @@
module stt_cell (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_adv,
    input  stt_pkg::t_req  i_req,
    input  stt_pkg::t_link i_link,
    output stt_pkg::t_link o_link,
    output stt_pkg::t_evt  o_evt
);
    import stt_pkg::*;

    logic                r_tok;
    t_status             r_stat;
    logic                r_valid, n_valid;
    logic                r_repeat, n_repeat;
    logic [TASK_W-1:0]   r_task, n_task;
    logic [SIGNAL_W-1:0] r_sig, n_sig;
    logic [TICKS_W-1:0]  r_count, n_count;
    logic [TICKS_W-1:0]  r_period, n_period;
    logic                match;
    t_status             stat_out;

    assign match = r_valid && (r_task == i_req.task_id) && (r_sig == i_req.signal_code);

    always_comb begin
        n_valid    = r_valid;
        n_repeat   = r_repeat;
        n_task     = r_task;
        n_sig      = r_sig;
        n_count    = r_count;
        n_period   = r_period;
        stat_out   = r_stat;
        o_evt.emit        = 1'b0;
        o_evt.task_id     = r_task;
        o_evt.signal_code = r_sig;
        if (r_tok) begin
            case (i_req.req_type) inside
                REQ_TICK: begin
                    if (r_valid) begin
                        if (r_count != '0) begin
                            n_count = r_count - TICKS_W'(1);
                        end else begin
                            o_evt.emit = 1'b1;
                            if (r_repeat) begin
                                n_count = r_period;
                            end else begin
                                n_valid = 1'b0;
                            end
                        end
                    end
                end
                REQ_SET_ONCE, REQ_SET_PERIODIC: begin
                    if (r_stat == ST_NONE) begin
                        if (match) begin
                            stat_out = ST_UPDATED;
                            if (i_req.req_type == REQ_SET_ONCE) begin
                                n_count = i_req.ticks;
                            end else begin
                                n_period = i_req.ticks;
                            end
                        end else if (!r_valid) begin
                            stat_out = ST_NEW;
                            n_valid  = 1'b1;
                            n_task   = i_req.task_id;
                            n_sig    = i_req.signal_code;
                            n_count  = i_req.ticks;
                            if (i_req.req_type == REQ_SET_ONCE) begin
                                n_repeat = 1'b0;
                            end else begin
                                n_repeat = 1'b1;
                                n_period = i_req.ticks;
                            end
                        end
                    end
                end
                default: begin
                    if (r_stat == ST_NONE && match) begin
                        stat_out = ST_UPDATED;
                        n_valid  = 1'b0;
                        n_repeat = 1'b0;
                    end
                end
            endcase
        end
    end

    assign o_link.tok    = r_tok;
    assign o_link.status = stat_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tok    <= 1'b0;
            r_stat   <= ST_NONE;
            r_valid  <= 1'b0;
            r_repeat <= 1'b0;
        end else if (i_adv) begin
            r_tok    <= i_link.tok;
            r_stat   <= i_link.status;
            r_valid  <= n_valid;
            r_repeat <= n_repeat;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_task   <= n_task;
            r_sig    <= n_sig;
            r_count  <= n_count;
            r_period <= n_period;
        end
    end

endmodule

@@ hdl/software_timer_table.sv @@
// A pool of timer slots kept in a chain of slot cells. An accepted word starts a
// token at the first cell that moves one cell per cycle while the chain is not
// stalled; each cell counts down, expires, takes, updates or frees its slot as
// the token passes, and a command stops acting after the first cell that serves
// it. After the token has walked the chain, a finishing state and then the idle
// state follow, and the next word is taken in the idle state; the walk and the
// finish wait while the result register is held by the sink. Expiry events leave
// in slot order with the last one of a tick marked; set and delete commands give
// one acknowledge.
module software_timer_table #(
    parameter int TIMER_SLOTS = stt_pkg::TIMER_SLOTS_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    stt_in_if.sink    i_req,
    stt_out_if.source o_rsp
);
    import stt_pkg::*;

    t_state              r_state, n_state;
    t_req                r_req;
    t_status             r_fin_status;
    logic                r_pend_valid;
    logic [TASK_W-1:0]   r_pend_task;
    logic [SIGNAL_W-1:0] r_pend_sig;
    logic                r_out_valid;
    logic                r_out_kind;
    logic [TASK_W-1:0]   r_out_task;
    logic [SIGNAL_W-1:0] r_out_sig;
    t_status             r_out_status;
    logic                r_out_last;

    t_link               link [TIMER_SLOTS+1];
    t_evt                cell_evt [TIMER_SLOTS];
    logic [TIMER_SLOTS-1:0] tok_vec;
    logic                evt_any;
    logic [TASK_W-1:0]   evt_task;
    logic [SIGNAL_W-1:0] evt_sig;
    logic                accept, out_free, stall, advance, chain_exit, is_tick;
    logic                push_pend_run, push_pend_fin, push_ack;

    assign accept   = i_req.valid && i_req.ready;
    assign out_free = !r_out_valid || o_rsp.ready;
    assign is_tick  = (r_req.req_type == REQ_TICK);
    assign stall    = (r_state == S_RUN) && evt_any && r_pend_valid && !out_free;
    assign advance  = !stall;
    assign chain_exit = tok_vec[TIMER_SLOTS-1] && advance;

    assign link[0].tok    = accept;
    assign link[0].status = ST_NONE;

    for (genvar g = 0; g < TIMER_SLOTS; g++) begin : g_cell
        stt_cell u_cell (
            .i_clk  (i_clk),
            .i_rst_n(i_rst_n),
            .i_adv  (advance),
            .i_req  (r_req),
            .i_link (link[g]),
            .o_link (link[g+1]),
            .o_evt  (cell_evt[g])
        );
    end

    always_comb begin
        evt_any  = 1'b0;
        evt_task = '0;
        evt_sig  = '0;
        tok_vec  = '0;
        for (int k = 0; k < TIMER_SLOTS; k++) begin
            tok_vec[k] = link[k+1].tok;
            if (cell_evt[k].emit) begin
                evt_any  = 1'b1;
                evt_task = evt_task | cell_evt[k].task_id;
                evt_sig  = evt_sig | cell_evt[k].signal_code;
            end
        end
    end

    always_comb begin
        n_state       = r_state;
        push_pend_run = 1'b0;
        push_pend_fin = 1'b0;
        push_ack      = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_state = S_RUN;
                end
            end
            S_RUN: begin
                push_pend_run = advance && evt_any && r_pend_valid;
                if (chain_exit) begin
                    n_state = S_FINISH;
                end
            end
            S_FINISH: begin
                if (is_tick) begin
                    if (!r_pend_valid) begin
                        n_state = S_IDLE;
                    end else if (out_free) begin
                        push_pend_fin = 1'b1;
                        n_state       = S_IDLE;
                    end
                end else if (out_free) begin
                    push_ack = 1'b1;
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_pend_valid <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == S_RUN && advance && evt_any) begin
                r_pend_valid <= 1'b1;
            end else if (push_pend_fin) begin
                r_pend_valid <= 1'b0;
            end
            if (push_pend_run || push_pend_fin || push_ack) begin
                r_out_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_req.req_type    <= t_req_type'(i_req.req_type);
            r_req.task_id     <= i_req.task_id;
            r_req.signal_code <= i_req.signal_code;
            r_req.ticks       <= i_req.ticks;
        end
        if (chain_exit) begin
            r_fin_status <= link[TIMER_SLOTS].status;
        end
        if (r_state == S_RUN && advance && evt_any) begin
            r_pend_task <= evt_task;
            r_pend_sig  <= evt_sig;
        end
        if (push_pend_run || push_pend_fin) begin
            r_out_kind   <= KIND_EVENT;
            r_out_task   <= r_pend_task;
            r_out_sig    <= r_pend_sig;
            r_out_status <= ST_UPDATED;
            r_out_last   <= push_pend_fin;
        end else if (push_ack) begin
            r_out_kind   <= KIND_ACK;
            r_out_task   <= r_req.task_id;
            r_out_sig    <= r_req.signal_code;
            r_out_status <= r_fin_status;
            r_out_last   <= 1'b1;
        end
    end

    assign i_req.ready        = (r_state == S_IDLE);
    assign o_rsp.valid        = r_out_valid;
    assign o_rsp.kind         = r_out_kind;
    assign o_rsp.event_task   = r_out_task;
    assign o_rsp.event_signal = r_out_sig;
    assign o_rsp.status       = r_out_status;
    assign o_rsp.last         = r_out_last;

`ifndef NO_ASSERTIONS
    a_token_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(tok_vec))
        else $error("more than one slot cell holds the token");

    a_idle_no_token: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> (tok_vec == '0))
        else $error("token in the chain while the block is idle");

    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        stall |-> (r_out_valid && r_pend_valid && evt_any))
        else $error("chain stalled without a blocked event");

    a_cmd_no_pend: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE && !is_tick) |-> !r_pend_valid)
        else $error("pending event held during a command");

    a_run_to_finish: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RUN && chain_exit) |=> (r_state == S_FINISH))
        else $error("token left the chain without finishing");
`endif

endmodule

@@ tb/tb_software_timer_table.sv @@
module tb_software_timer_table;
    import stt_pkg::*;

    localparam int SLOTS        = TIMER_SLOTS_DEF;
    localparam int RANDOM_ITEMS = 400;

    typedef struct {
        t_req_type             op;
        logic [TASK_W-1:0]     task_id;
        logic [SIGNAL_W-1:0]   sig;
        logic [TICKS_W-1:0]    ticks;
        bit                    drain;
    } timer_req_t;

    typedef struct {
        t_kind                 kind;
        logic [TASK_W-1:0]     task_id;
        logic [SIGNAL_W-1:0]   sig;
        t_status               status;
        logic                  last;
    } timer_word_t;

    logic i_clk;
    logic i_rst_n;

    stt_in_if  req_if ();
    stt_out_if rsp_if ();

    software_timer_table #(.TIMER_SLOTS(SLOTS)) dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (req_if),
        .o_rsp  (rsp_if)
    );

    timer_req_t  queued_requests[$];
    timer_word_t due_timer_words[$];
    timer_req_t  in_flight;
    timer_word_t want;

    bit                  slot_busy[SLOTS];
    logic [TASK_W-1:0]   slot_owner[SLOTS];
    logic [SIGNAL_W-1:0] slot_sig[SLOTS];
    logic [TICKS_W-1:0]  slot_left[SLOTS];
    logic [TICKS_W-1:0]  slot_reload[SLOTS];
    bit                  slot_periodic[SLOTS];

    int n_accepted = 0;
    int n_errors   = 0;
    int n_expiries = 0;
    int n_taken    = 0;
    int n_updated  = 0;
    int n_refused  = 0;

    logic steady;
    assign steady = (n_accepted >= 150) && (n_accepted < 260);

    always begin
        i_clk = 1'b0;
        #4;
        i_clk = 1'b1;
        #4;
    end

    initial begin
        req_if.valid       = 1'b0;
        req_if.req_type    = REQ_TICK;
        req_if.task_id     = '0;
        req_if.signal_code = '0;
        req_if.ticks       = '0;
        rsp_if.ready       = 1'b0;
    end

    function automatic void apply_timer_request(input timer_req_t r);
        int      last_fire;
        int      hit;
        t_status st;
        last_fire = -1;
        hit       = -1;
        st        = ST_NONE;
        if (r.op == REQ_TICK) begin
            // A slot fires only if its count is zero before the tick, so the final
            // word of the tick is known before any slot changes.
            for (int i = 0; i < SLOTS; i++) begin
                if (slot_busy[i] && slot_left[i] == 0) begin
                    last_fire = i;
                end
            end
            for (int i = 0; i < SLOTS; i++) begin
                if (slot_busy[i]) begin
                    if (slot_left[i] != 0) begin
                        slot_left[i] = slot_left[i] - TICKS_W'(1);
                    end else begin
                        due_timer_words.push_back('{KIND_EVENT, slot_owner[i], slot_sig[i],
                                                    ST_UPDATED, i == last_fire});
                        n_expiries++;
                        if (slot_periodic[i]) begin
                            slot_left[i] = slot_reload[i];
                        end else begin
                            slot_busy[i] = 1'b0;
                        end
                    end
                end
            end
            return;
        end
        for (int i = 0; i < SLOTS && hit < 0; i++) begin
            if (slot_busy[i] && slot_owner[i] == r.task_id && slot_sig[i] == r.sig) begin
                hit = i;
            end else if (!slot_busy[i] && r.op != REQ_DELETE) begin
                hit = i;
            end
        end
        if (hit >= 0) begin
            if (r.op == REQ_DELETE) begin
                slot_busy[hit]     = 1'b0;
                slot_periodic[hit] = 1'b0;
                st = ST_UPDATED;
            end else if (slot_busy[hit]) begin
                if (r.op == REQ_SET_ONCE) begin
                    slot_left[hit] = r.ticks;
                end else begin
                    slot_reload[hit] = r.ticks;
                end
                st = ST_UPDATED;
            end else begin
                slot_busy[hit]     = 1'b1;
                slot_owner[hit]    = r.task_id;
                slot_sig[hit]      = r.sig;
                slot_left[hit]     = r.ticks;
                slot_periodic[hit] = (r.op == REQ_SET_PERIODIC);
                if (r.op == REQ_SET_PERIODIC) begin
                    slot_reload[hit] = r.ticks;
                end
                st = ST_NEW;
            end
        end
        case (st)
            ST_UPDATED: n_updated++;
            ST_NEW:     n_taken++;
            default:    n_refused++;
        endcase
        due_timer_words.push_back('{KIND_ACK, r.task_id, r.sig, st, 1'b1});
    endfunction

    task automatic report_mismatch(input string what);
        n_errors++;
        if (n_errors <= 10) begin
            $display("%s: expected kind %0d task %0d signal %0d status %0d last %0d,",
                     what, want.kind, want.task_id, want.sig, want.status, want.last);
            $display("    got kind %0d task %0d signal %0d status %0d last %0d",
                     rsp_if.kind, rsp_if.event_task, rsp_if.event_signal, rsp_if.status,
                     rsp_if.last);
        end
    endtask

    task automatic add_req(input t_req_type op, input logic [TASK_W-1:0] task_id,
                           input logic [SIGNAL_W-1:0] sig, input logic [TICKS_W-1:0] ticks,
                           input bit drain);
        queued_requests.push_back('{op, task_id, sig, ticks, drain});
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            req_if.valid <= 1'b0;
        end else begin
            if (req_if.valid && req_if.ready) begin
                apply_timer_request(in_flight);
                n_accepted++;
            end
            if (!req_if.valid || req_if.ready) begin
                if (queued_requests.size() != 0
                        && !(queued_requests[0].drain && due_timer_words.size() != 0)
                        && (steady || $urandom_range(99) >= 31)) begin
                    in_flight = queued_requests.pop_front();
                    req_if.valid       <= 1'b1;
                    req_if.req_type    <= in_flight.op;
                    req_if.task_id     <= in_flight.task_id;
                    req_if.signal_code <= in_flight.sig;
                    req_if.ticks       <= in_flight.ticks;
                end else begin
                    req_if.valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            rsp_if.ready <= 1'b0;
        end else begin
            if (rsp_if.valid && rsp_if.ready) begin
                if (due_timer_words.size() == 0) begin
                    want = '{KIND_EVENT, '0, '0, ST_UPDATED, 1'b0};
                    report_mismatch("Unexpected word");
                end else begin
                    want = due_timer_words.pop_front();
                    if (rsp_if.kind !== want.kind || rsp_if.event_task !== want.task_id
                            || rsp_if.event_signal !== want.sig
                            || rsp_if.status !== want.status || rsp_if.last !== want.last) begin
                        report_mismatch("Mismatch");
                    end
                end
            end
            rsp_if.ready <= steady || ($urandom_range(99) >= 31);
        end
    end

    initial begin
        timer_req_t r;
        int         pick;
        i_rst_n = 1'b0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        add_req(REQ_TICK, 8'h00, 8'h00, 16'h0000, 1'b0);
        add_req(REQ_DELETE, 8'd9, 8'd9, 16'h0000, 1'b0);
        add_req(REQ_SET_ONCE, 8'hFF, 8'hFF, 16'h0000, 1'b0);
        add_req(REQ_SET_PERIODIC, 8'h00, 8'h00, 16'h0000, 1'b0);
        add_req(REQ_TICK, 8'hFF, 8'hFF, 16'hFFFF, 1'b0);
        add_req(REQ_SET_ONCE, 8'h00, 8'h00, 16'd3, 1'b1);
        add_req(REQ_SET_PERIODIC, 8'h00, 8'h00, 16'd1, 1'b0);
        for (int k = 1; k <= 7; k++) begin
            add_req(REQ_SET_ONCE, 8'(k), 8'(8'h80 | k), 16'hFFFF, 1'b0);
        end
        add_req(REQ_SET_PERIODIC, 8'hAA, 8'h55, 16'd5, 1'b0);
        add_req(REQ_DELETE, 8'd1, 8'h81, 16'h0000, 1'b0);
        add_req(REQ_SET_ONCE, 8'd2, 8'h82, 16'd4, 1'b0);
        for (int k = 0; k < 3; k++) begin
            add_req(REQ_DELETE, 8'd2, 8'h82, 16'h0000, 1'b0);
        end
        for (int k = 0; k < 4; k++) begin
            add_req(REQ_TICK, 8'(k), 8'(k), 16'(k), 1'b0);
        end

        // Most keys come from a small set so that matches, duplicates and a full
        // pool are common; small counts keep the expiries flowing.
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            pick = $urandom_range(99);
            r.op = (pick < 40) ? REQ_TICK : (pick < 65) ? REQ_SET_ONCE :
                   (pick < 80) ? REQ_SET_PERIODIC : REQ_DELETE;
            if ($urandom_range(3) != 0) begin
                r.task_id = 8'($urandom_range(3));
                r.sig     = 8'($urandom_range(1));
            end else begin
                r.task_id = 8'($urandom);
                r.sig     = 8'($urandom);
            end
            r.ticks = ($urandom_range(15) == 0) ? 16'($urandom) : 16'($urandom_range(6));
            r.drain = (n % 90 == 45);
            queued_requests.push_back(r);
        end

        while (queued_requests.size() != 0 || req_if.valid) @(posedge i_clk);
        while (due_timer_words.size() != 0) @(posedge i_clk);
        repeat (4 * SLOTS + 8) @(posedge i_clk);

        $display("Ran %0d requests: %0d slots taken, %0d updated or deleted, %0d refused,",
                 n_accepted, n_taken, n_updated, n_refused);
        $display("and %0d expiry events, with stalls on both sides and a drained pause.",
                 n_expiries);
        if (n_errors == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

    initial begin
        #3000000;
        $display("Timeout with %0d words still due.", due_timer_words.size());
        $display("Testbench completed WITH ERRORS");
        $finish;
    end
endmodule

@@ sim.f @@
hdl/stt_pkg.sv
hdl/stt_in_if.sv
hdl/stt_out_if.sv
hdl/stt_cell.sv
hdl/software_timer_table.sv
tb/tb_software_timer_table.sv
